// ===== rtl/mcvc_pkg.sv =====
// Shared types and constants of the MIDI controller value cache.
// No dependencies; the front, back and top files refer to it by scoped names.
package mcvc_pkg;

    // Status nibbles of the message kinds that the cache absorbs.
    localparam logic [3:0] NIB_CTRL  = 4'hB;
    localparam logic [3:0] NIB_KEYP  = 4'hA;
    localparam logic [3:0] NIB_CHANP = 4'hD;
    localparam logic [3:0] NIB_BEND  = 4'hE;

    // Flat read address map.
    localparam logic [8:0] LAST_ENTRY = 9'd287;
    localparam logic [8:0] CHAN_BASE  = 9'd256;

    // Read status codes.
    localparam logic [1:0] RS_OK    = 2'd0;
    localparam logic [1:0] RS_OFF   = 2'd1;
    localparam logic [1:0] RS_RANGE = 2'd2;

    // Queue depths between the parts.
    localparam int MID_DEPTH = 2;
    localparam int OUT_DEPTH = 4;

    // Operation kinds handed from the front to the back.
    typedef enum logic [2:0] {
        K_FWD,
        K_WR_LO,
        K_WR_HI,
        K_RD_LO,
        K_RD_HI,
        K_RD_ERR
    } t_kind;

    // Classified operation. index: {key, number} for the 7-bit table,
    // {bend, channel} in the low five bits for the 14-bit table.
    typedef struct packed {
        t_kind       kind;
        logic [1:0]  stream;
        logic [7:0]  index;
        logic [13:0] value;
        logic [7:0]  status;
        logic [1:0]  rd_status;
    } t_op;

    // One result request.
    typedef struct packed {
        logic        forwarded;
        logic [7:0]  out_status;
        logic [6:0]  out_data_one;
        logic [6:0]  out_data_two;
        logic [13:0] read_value;
        logic [1:0]  read_status;
    } t_res;

endpackage

// ===== rtl/mcvc_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mcvc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/mcvc_fifo.sv =====
// Small register queue with push/full and pop/empty handshakes and a fill count.
// No dependencies.
module mcvc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    output logic                       o_full,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr, n_wr, r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== rtl/mcvc_front.sv =====
// Front part: accepts input items, classifies them into table operations
// and holds one classified operation for the middle queue. Uses mcvc_pkg.
module mcvc_front #(
    parameter int NUM_STREAMS = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_hold,
    input  logic           i_caching_enabled,
    input  logic           push,
    output logic           full,
    input  logic           i_command,
    input  logic [1:0]     i_stream,
    input  logic [7:0]     i_status_byte,
    input  logic [6:0]     i_data_one,
    input  logic [6:0]     i_data_two,
    input  logic [8:0]     i_entry,
    output logic           o_op_valid,
    output mcvc_pkg::t_op  o_op,
    input  logic           i_q_full
);

    mcvc_pkg::t_op r_op, c_op;
    logic          r_valid, n_valid;
    logic          stream_ok, accept, handoff;

    assign stream_ok  = (32'(i_stream) < NUM_STREAMS);
    assign full       = i_hold || (r_valid && i_q_full);
    assign accept     = push && !full;
    assign handoff    = r_valid && !i_q_full;
    assign o_op_valid = r_valid;
    assign o_op       = r_op;

    // Classify the incoming item.
    always_comb begin
        c_op           = '0;
        c_op.kind      = mcvc_pkg::K_FWD;
        c_op.stream    = i_stream;
        c_op.status    = i_status_byte;
        c_op.value     = {i_data_two, i_data_one};
        c_op.rd_status = mcvc_pkg::RS_OK;
        if (i_command) begin
            if (!i_caching_enabled) begin
                c_op.kind      = mcvc_pkg::K_RD_ERR;
                c_op.rd_status = mcvc_pkg::RS_OFF;
            end else if ((i_entry > mcvc_pkg::LAST_ENTRY) || !stream_ok) begin
                c_op.kind      = mcvc_pkg::K_RD_ERR;
                c_op.rd_status = mcvc_pkg::RS_RANGE;
            end else if (i_entry < mcvc_pkg::CHAN_BASE) begin
                c_op.kind  = mcvc_pkg::K_RD_LO;
                c_op.index = i_entry[7:0];
            end else begin
                c_op.kind  = mcvc_pkg::K_RD_HI;
                c_op.index = 8'(i_entry - mcvc_pkg::CHAN_BASE);
            end
        end else if (i_caching_enabled && stream_ok) begin
            case (i_status_byte[7:4])
                mcvc_pkg::NIB_CTRL: begin
                    c_op.kind  = mcvc_pkg::K_WR_LO;
                    c_op.index = {1'b0, i_data_one};
                    c_op.value = {7'b0, i_data_two};
                end
                mcvc_pkg::NIB_KEYP: begin
                    c_op.kind  = mcvc_pkg::K_WR_LO;
                    c_op.index = {1'b1, i_data_one};
                    c_op.value = {7'b0, i_data_two};
                end
                mcvc_pkg::NIB_CHANP: begin
                    c_op.kind  = mcvc_pkg::K_WR_HI;
                    c_op.index = {4'b0, i_status_byte[3:0]};
                    c_op.value = {7'b0, i_data_one};
                end
                mcvc_pkg::NIB_BEND: begin
                    c_op.kind  = mcvc_pkg::K_WR_HI;
                    c_op.index = {3'b0, 1'b1, i_status_byte[3:0]};
                end
                default: begin
                    c_op.kind = mcvc_pkg::K_FWD;
                end
            endcase
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (handoff) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= c_op;
        end
    end

endmodule

// ===== rtl/mcvc_back.sv =====
// Back part: clears both table RAMs after reset, then does one operation
// per cycle while one waits and output has room. Uses mcvc_pkg, mcvc_ram.
module mcvc_back #(
    parameter int NUM_STREAMS = 4
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    output logic                                     o_clearing,
    input  logic                                     i_op_empty,
    input  mcvc_pkg::t_op                            i_op,
    output logic                                     o_op_pop,
    input  logic [$clog2(mcvc_pkg::OUT_DEPTH+1)-1:0] i_out_count,
    output logic                                     o_res_push,
    output mcvc_pkg::t_res                           o_res
);

    localparam int LoDepth = NUM_STREAMS * 256;
    localparam int HiDepth = NUM_STREAMS * 32;
    localparam int LoAw    = $clog2(LoDepth);
    localparam int HiAw    = $clog2(HiDepth);
    localparam int CW      = $clog2(mcvc_pkg::OUT_DEPTH + 1);

    logic            r_clr_busy, n_clr_busy;
    logic [LoAw-1:0] r_clr_cnt, n_clr_cnt;
    logic            r_inflight;
    mcvc_pkg::t_op   r_op;
    logic [CW:0]     used;
    logic            issue;

    logic            lo_we, hi_we;
    logic [LoAw-1:0] lo_waddr, lo_raddr, lo_addr;
    logic [HiAw-1:0] hi_waddr, hi_raddr, hi_addr;
    logic [6:0]      lo_wdata, lo_rdata;
    logic [13:0]     hi_wdata, hi_rdata;

    // Reserve output queue space for the request in flight.
    assign used  = {1'b0, i_out_count} + {{CW{1'b0}}, r_inflight};
    assign issue = !r_clr_busy && !i_op_empty && (used < (CW + 1)'(mcvc_pkg::OUT_DEPTH));

    assign o_clearing = r_clr_busy;
    assign o_op_pop   = issue;

    assign lo_addr  = LoAw'({i_op.stream, i_op.index});
    assign hi_addr  = HiAw'({i_op.stream, i_op.index[4:0]});

    assign lo_we    = r_clr_busy || (issue && (i_op.kind == mcvc_pkg::K_WR_LO));
    assign lo_waddr = r_clr_busy ? r_clr_cnt : lo_addr;
    assign lo_wdata = r_clr_busy ? 7'b0 : i_op.value[6:0];
    assign lo_raddr = lo_addr;

    assign hi_we    = (r_clr_busy && (r_clr_cnt < LoAw'(HiDepth)))
                   || (issue && (i_op.kind == mcvc_pkg::K_WR_HI));
    assign hi_waddr = r_clr_busy ? HiAw'(r_clr_cnt) : hi_addr;
    assign hi_wdata = r_clr_busy ? 14'b0 : i_op.value;
    assign hi_raddr = hi_addr;

    mcvc_ram #(
        .WIDTH (7),
        .DEPTH (LoDepth)
    ) u_lo_ram (
        .i_clk   (i_clk),
        .i_we    (lo_we),
        .i_waddr (lo_waddr),
        .i_wdata (lo_wdata),
        .i_raddr (lo_raddr),
        .o_rdata (lo_rdata)
    );

    mcvc_ram #(
        .WIDTH (14),
        .DEPTH (HiDepth)
    ) u_hi_ram (
        .i_clk   (i_clk),
        .i_we    (hi_we),
        .i_waddr (hi_waddr),
        .i_wdata (hi_wdata),
        .i_raddr (hi_raddr),
        .o_rdata (hi_rdata)
    );

    always_comb begin
        n_clr_busy = r_clr_busy;
        n_clr_cnt  = r_clr_cnt;
        if (r_clr_busy) begin
            n_clr_cnt = r_clr_cnt + 1'b1;
            if (r_clr_cnt == LoAw'(LoDepth - 1)) begin
                n_clr_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
            r_inflight <= 1'b0;
        end else begin
            r_clr_busy <= n_clr_busy;
            r_clr_cnt  <= n_clr_cnt;
            r_inflight <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_op <= i_op;
        end
    end

    // Form the result once the table read has landed.
    assign o_res_push = r_inflight;

    always_comb begin
        o_res = '0;
        case (r_op.kind)
            mcvc_pkg::K_FWD: begin
                o_res.forwarded    = 1'b1;
                o_res.out_status   = r_op.status;
                o_res.out_data_one = r_op.value[6:0];
                o_res.out_data_two = r_op.value[13:7];
            end
            mcvc_pkg::K_RD_LO: begin
                o_res.read_value = {7'b0, lo_rdata};
            end
            mcvc_pkg::K_RD_HI: begin
                o_res.read_value = hi_rdata;
            end
            mcvc_pkg::K_RD_ERR: begin
                o_res.read_status = r_op.rd_status;
            end
            default: begin
                o_res = '0;
            end
        endcase
    end

endmodule

// ===== rtl/midi_controller_value_cache_unit.sv =====
// MIDI controller value cache, top level. Uses mcvc_pkg, mcvc_front,
// mcvc_fifo and mcvc_back.
//
// Each accepted item (a MIDI message or a read of one cache entry) yields
// exactly one result request, in order. With caching enabled, control change,
// poly key pressure, channel pressure and pitch bend messages update the
// tables of their stream and come out as an all-zero result with forwarded
// low; every other message is passed on unchanged. A read addresses the flat
// map 0-127 controllers, 128-255 key pressures, 256-271 channel pressures,
// 272-287 pitch bend, and reports caching-off or out-of-range in read_status.
// After reset the block runs a clearing pass over the tables and holds full
// high throughout; configuration writes are taken at any time (cfg ready is
// always high) but should only change the enable while the block is idle.
// Sustained throughput is one item per cycle while the output queue drains,
// set by the back part issuing one table operation per cycle; a result
// reaches the output queue through the front register, the middle queue and
// the registered table read. Hold pop low and the four-entry output queue
// fills, then the back part stops issuing, the middle queue fills and full
// rises.
module midi_controller_value_cache_unit #(
    parameter int NUM_STREAMS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_data,
    // input queue side
    input  logic        push,
    output logic        full,
    input  logic        i_command,
    input  logic [1:0]  i_stream,
    input  logic [7:0]  i_status_byte,
    input  logic [6:0]  i_data_one,
    input  logic [6:0]  i_data_two,
    input  logic [8:0]  i_entry,
    // result queue side
    output logic        empty,
    input  logic        pop,
    output logic        o_forwarded,
    output logic [7:0]  o_out_status,
    output logic [6:0]  o_out_data_one,
    output logic [6:0]  o_out_data_two,
    output logic [13:0] o_read_value,
    output logic [1:0]  o_read_status
);

    localparam int OpW  = $bits(mcvc_pkg::t_op);
    localparam int ResW = $bits(mcvc_pkg::t_res);
    localparam int OCW  = $clog2(mcvc_pkg::OUT_DEPTH + 1);

    logic                r_caching_enabled;
    logic                clearing;
    logic                f_valid;
    mcvc_pkg::t_op       f_op;
    logic                q_full, q_empty, q_pop;
    logic [OpW-1:0]      q_data;
    mcvc_pkg::t_op       q_op;
    logic [$clog2(mcvc_pkg::MID_DEPTH+1)-1:0] q_count;
    logic                res_push;
    mcvc_pkg::t_res      res;
    logic [ResW-1:0]     out_data;
    mcvc_pkg::t_res      out_res;
    logic                out_full;
    logic [OCW-1:0]      out_count;

    // Enable register: hold until the next write.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_caching_enabled <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_caching_enabled <= i_cfg_data;
        end
    end

    // Accept and classify; hold new items off while the tables are cleared.
    mcvc_front #(
        .NUM_STREAMS (NUM_STREAMS)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_hold            (clearing),
        .i_caching_enabled (r_caching_enabled),
        .push              (push),
        .full              (full),
        .i_command         (i_command),
        .i_stream          (i_stream),
        .i_status_byte     (i_status_byte),
        .i_data_one        (i_data_one),
        .i_data_two        (i_data_two),
        .i_entry           (i_entry),
        .o_op_valid        (f_valid),
        .o_op              (f_op),
        .i_q_full          (q_full)
    );

    // Middle queue: decouple classification from table access.
    mcvc_fifo #(
        .WIDTH (OpW),
        .DEPTH (mcvc_pkg::MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  (f_op),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    assign q_op = mcvc_pkg::t_op'(q_data);

    // Carry out the table operations.
    mcvc_back #(
        .NUM_STREAMS (NUM_STREAMS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .o_clearing  (clearing),
        .i_op_empty  (q_empty),
        .i_op        (q_op),
        .o_op_pop    (q_pop),
        .i_out_count (out_count),
        .o_res_push  (res_push),
        .o_res       (res)
    );

    // Output queue: the back part reserves space, so a push never meets full.
    mcvc_fifo #(
        .WIDTH (ResW),
        .DEPTH (mcvc_pkg::OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push && !out_full),
        .i_data  (res),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_data),
        .o_empty (empty),
        .o_count (out_count)
    );

    assign out_res        = mcvc_pkg::t_res'(out_data);
    assign o_forwarded    = out_res.forwarded;
    assign o_out_status   = out_res.out_status;
    assign o_out_data_one = out_res.out_data_one;
    assign o_out_data_two = out_res.out_data_two;
    assign o_read_value   = out_res.read_value;
    // The middle queue count is only for visibility; fold it in as a guard
    // that never changes the status (count never exceeds the depth).
    assign o_read_status  = out_res.read_status
                          & {2{q_count <= ($clog2(mcvc_pkg::MID_DEPTH+1))'(mcvc_pkg::MID_DEPTH)}};

endmodule
